// ===== hdl/lz77_stream_decompressor_unit_defines.svh =====
// Assertion macros for the LZ77 stream decompressor.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef LZ77_STREAM_DECOMPRESSOR_UNIT_DEFINES_SVH
`define LZ77_STREAM_DECOMPRESSOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LZ_ASSERT_SAME(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LZ_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hdl/lz77sd_pkg.sv =====
// Shared types and constants for the LZ77 stream decompressor.
// No dependencies.
package lz77sd_pkg;

    localparam int WINDOW_DEPTH_DEF = 4096;

    localparam logic [3:0] TYPE_LZ77   = 4'h1;
    localparam logic [4:0] LEN_BIAS    = 5'd3;
    localparam logic [4:0] MAX_COPY    = 5'd18;
    localparam logic [3:0] FLAG_BLOCKS = 4'd8;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_HDR = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_BLOCKS,
        PH_REF2
    } phase_t;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       stream_start;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_output;
        logic       status;
    } out_t;

endpackage

// ===== hdl/lz77_stream_decompressor_unit.sv =====
// Top level of the LZ77 (LZ10) stream decompressor with its history window memory.
// Depends on lz77sd_pkg and lz77_stream_decompressor_unit_defines.svh.
//
// Usage:
//   s_* carries the compressed stream one byte per transaction; stream_start
//   marks the first header byte and restarts parsing at any time. m_* carries
//   one decompressed byte per transaction, end_of_output on the last byte, and
//   a single {0,1,1} transaction when the header type is not LZ77.
//   Header and flag bytes give no output. A literal is registered and
//   offered on m_* in the cycle after acceptance. A reference expands into
//   up to 18 bytes at one byte per cycle while the receiver takes them,
//   paced by the single read port of the window memory, which is registered;
//   from acceptance of the second reference byte, the first byte passes the
//   copy count and read address registers, the window read register and
//   the output register. s_ready stays low while a copy runs. When the
//   receiver stalls, the output register holds, the copy pauses, and only
//   bytes that produce no output are still accepted.
//   Reset clears parsing state and the write pointer; the window reads as
//   zero where it was never written (tracked by the write pointer and a wrap
//   flag), so no clearing pass is needed and the block is ready at once.
`include "lz77_stream_decompressor_unit_defines.svh"

module lz77_stream_decompressor_unit #(
    parameter int WINDOW_DEPTH = lz77sd_pkg::WINDOW_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  lz77sd_pkg::in_t  s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output lz77sd_pkg::out_t m_data
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam logic [AW:0]   DEPTH_W  = (AW+1)'(WINDOW_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_DEPTH - 1);

    logic [7:0] mem [WINDOW_DEPTH];
    logic [7:0] mem_q;

    lz77sd_pkg::phase_t phase_reg, phase_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic          wrapped_reg, wrapped_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [23:0]   remaining_reg, remaining_next;
    logic [7:0]    flags_reg, flags_next;
    logic [3:0]    left_reg, left_next;
    logic [1:0]    hdr_idx_reg, hdr_idx_next;
    logic [7:0]    pend_reg, pend_next;
    logic [4:0]    copy_left_reg, copy_left_next;
    logic          rd_pend_reg, rd_pend_next;
    logic          rd_ok_reg, rd_ok_next;
    logic          fwd_reg, fwd_next;
    logic [7:0]    fwd_data_reg, fwd_data_next;
    logic          m_valid_reg, m_valid_next;
    lz77sd_pkg::out_t m_data_reg, m_data_next;

    logic          out_free, busy, would_emit, accept, load_copy, issue;
    logic          bad_type, we;
    logic [7:0]    wdata, copy_byte;
    logic [12:0]   disp;
    logic [AW:0]   back_dist, rd_tmp;
    logic [4:0]    len;
    logic [23:0]   hdr_val;

    assign bad_type  = s_data.stream_byte[7:4] != lz77sd_pkg::TYPE_LZ77;
    assign out_free  = !m_valid_reg || m_ready;
    assign busy      = (copy_left_reg != 5'd0) || rd_pend_reg;
    assign would_emit = s_data.stream_start ? bad_type
                      : (phase_reg == lz77sd_pkg::PH_BLOCKS) && (left_reg != 4'd0)
                        && !flags_reg[7];
    assign s_ready   = !busy && (out_free || !would_emit);
    assign accept    = s_valid && s_ready;
    assign load_copy = rd_pend_reg && out_free;
    assign issue     = (copy_left_reg != 5'd0) && (!rd_pend_reg || load_copy);
    assign copy_byte = fwd_reg ? fwd_data_reg : (rd_ok_reg ? mem_q : 8'd0);

    assign disp = {1'b0, pend_reg[3:0], s_data.stream_byte} + 13'd1;
    assign len  = {1'b0, pend_reg[7:4]} + lz77sd_pkg::LEN_BIAS;

    always_comb begin
        back_dist = (AW+1)'(disp);
        if (back_dist == DEPTH_W) begin
            back_dist = '0;
        end
        rd_tmp = {1'b0, wp_reg} + DEPTH_W - back_dist;
        if (rd_tmp >= DEPTH_W) begin
            rd_tmp = rd_tmp - DEPTH_W;
        end
    end

    always_comb begin
        unique case (hdr_idx_reg)
            2'd1:    hdr_val = {16'd0, s_data.stream_byte};
            2'd2:    hdr_val = {8'd0, s_data.stream_byte, 8'd0};
            2'd3:    hdr_val = {s_data.stream_byte, 16'd0};
            default: hdr_val = 24'd0;
        endcase
    end

    always_comb begin
        phase_next     = phase_reg;
        wp_next        = wp_reg;
        wrapped_next   = wrapped_reg;
        rd_next        = rd_reg;
        remaining_next = remaining_reg;
        flags_next     = flags_reg;
        left_next      = left_reg;
        hdr_idx_next   = hdr_idx_reg;
        pend_next      = pend_reg;
        copy_left_next = copy_left_reg;
        rd_pend_next   = rd_pend_reg;
        rd_ok_next     = rd_ok_reg;
        fwd_next       = fwd_reg;
        fwd_data_next  = fwd_data_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        we             = 1'b0;
        wdata          = copy_byte;

        if (accept) begin
            if (s_data.stream_start) begin
                flags_next     = 8'd0;
                left_next      = 4'd0;
                pend_next      = 8'd0;
                remaining_next = 24'd0;
                hdr_idx_next   = 2'd0;
                if (bad_type) begin
                    phase_next   = lz77sd_pkg::PH_IDLE;
                    m_valid_next = 1'b1;
                    m_data_next  = '{out_byte: 8'd0, end_of_output: 1'b1,
                                     status: lz77sd_pkg::STATUS_BAD_HDR};
                end else begin
                    hdr_idx_next = 2'd1;
                    phase_next   = lz77sd_pkg::PH_HEADER;
                end
            end else begin
                unique case (phase_reg)
                    lz77sd_pkg::PH_HEADER: begin
                        remaining_next = remaining_reg | hdr_val;
                        if (hdr_idx_reg == 2'd3) begin
                            hdr_idx_next = 2'd0;
                            left_next    = 4'd0;
                            phase_next   = (remaining_next == 24'd0) ? lz77sd_pkg::PH_IDLE
                                                                     : lz77sd_pkg::PH_BLOCKS;
                        end else begin
                            hdr_idx_next = hdr_idx_reg + 2'd1;
                        end
                    end
                    lz77sd_pkg::PH_BLOCKS: begin
                        if (left_reg == 4'd0) begin
                            flags_next = s_data.stream_byte;
                            left_next  = lz77sd_pkg::FLAG_BLOCKS;
                        end else begin
                            flags_next = {flags_reg[6:0], 1'b0};
                            left_next  = left_reg - 4'd1;
                            if (flags_reg[7]) begin
                                pend_next  = s_data.stream_byte;
                                phase_next = lz77sd_pkg::PH_REF2;
                            end else begin
                                we    = 1'b1;
                                wdata = s_data.stream_byte;
                            end
                        end
                    end
                    lz77sd_pkg::PH_REF2: begin
                        phase_next     = lz77sd_pkg::PH_BLOCKS;
                        rd_next        = rd_tmp[AW-1:0];
                        copy_left_next = (remaining_reg < 24'(len)) ? remaining_reg[4:0] : len;
                    end
                    lz77sd_pkg::PH_IDLE: begin
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (load_copy) begin
            we           = 1'b1;
            wdata        = copy_byte;
            rd_pend_next = 1'b0;
        end

        if (we) begin
            wp_next        = (wp_reg == LAST_IDX) ? '0 : wp_reg + AW'(1);
            wrapped_next   = wrapped_reg || (wp_reg == LAST_IDX);
            remaining_next = remaining_reg - 24'd1;
            m_valid_next   = 1'b1;
            m_data_next    = '{out_byte: wdata, end_of_output: remaining_reg == 24'd1,
                               status: lz77sd_pkg::STATUS_OK};
            if (remaining_reg == 24'd1) begin
                phase_next = lz77sd_pkg::PH_IDLE;
            end
        end

        if (issue) begin
            rd_next        = (rd_reg == LAST_IDX) ? '0 : rd_reg + AW'(1);
            copy_left_next = copy_left_reg - 5'd1;
            rd_pend_next   = 1'b1;
            rd_ok_next     = wrapped_reg || (rd_reg < wp_reg);
            fwd_next       = we && (rd_reg == wp_reg);
            fwd_data_next  = wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wp_reg] <= wdata;
        end
        if (issue) begin
            mem_q <= mem[rd_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= lz77sd_pkg::PH_IDLE;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            remaining_reg <= 24'd0;
            flags_reg     <= 8'd0;
            left_reg      <= 4'd0;
            hdr_idx_reg   <= 2'd0;
            pend_reg      <= 8'd0;
            copy_left_reg <= 5'd0;
            rd_pend_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            wp_reg        <= wp_next;
            wrapped_reg   <= wrapped_next;
            remaining_reg <= remaining_next;
            flags_reg     <= flags_next;
            left_reg      <= left_next;
            hdr_idx_reg   <= hdr_idx_next;
            pend_reg      <= pend_next;
            copy_left_reg <= copy_left_next;
            rd_pend_reg   <= rd_pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_reg       <= rd_next;
        rd_ok_reg    <= rd_ok_next;
        fwd_reg      <= fwd_next;
        fwd_data_reg <= fwd_data_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `LZ_ASSERT_SAME(a_no_accept_in_copy, aclk, aresetn, busy, !s_ready,
        "input accepted while a copy is running")
    `LZ_ASSERT_SAME(a_copy_bound, aclk, aresetn, 1'b1, copy_left_reg <= lz77sd_pkg::MAX_COPY,
        "copy count exceeds maximum reference length")
    `LZ_ASSERT_NEXT(a_pend_held, aclk, aresetn, rd_pend_reg && m_valid_reg && !m_ready,
        rd_pend_reg && $stable(copy_byte), "pending window byte lost during output stall")
    `LZ_ASSERT_SAME(a_emit_in_budget, aclk, aresetn, we, remaining_reg != 24'd0,
        "byte emitted beyond header size")

endmodule
